FILE: design/rtssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio time slot sync controller package
// Shared types, codes and the state evaluation functions of the slot
// synchronizer.
// ----------------------------------------------------------------------------
package rtssc_pkg;

  localparam int ADDR_W      = 24;
  localparam int MS_W        = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Longest chain of evaluations that one settling pass can need, counting
  // the final evaluation that leaves the state unchanged.
  localparam int EVAL_STEPS = 4;

  localparam logic [MS_W-1:0]   LISTEN_RESET  = 16'd10;
  localparam logic [MS_W-1:0]   SEND_RESET    = 16'd1;
  localparam logic [MS_W-1:0]   MEASURE_RESET = 16'd2000;
  localparam logic [MS_W-1:0]   ELAPSED_MAX   = 16'hFFFF;
  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 24'hFFFFFF;

  localparam logic [7:0] MSG_BEACON    = 8'h24;
  localparam logic [7:0] MSG_COLLISION = 8'hDB;
  localparam logic [7:0] MSG_ACK       = 8'h81;
  localparam logic [7:0] MSG_MEASURE   = 8'h18;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_MESSAGE = 1'b1;

  typedef enum logic [3:0] {
    ST_RESET    = 4'd0,
    ST_SCAN     = 4'd1,
    ST_DETECTED = 4'd2,
    ST_SENDACK  = 4'd3,
    ST_WAITACK  = 4'd4,
    ST_SYNCED   = 4'd5,
    ST_BEACON   = 4'd6,
    ST_CHECK    = 4'd7,
    ST_WAITSLOT = 4'd8,
    ST_TAKE     = 4'd9
  } proto_state_t;

  typedef enum logic [1:0] {
    TX_BEACON    = 2'd0,
    TX_COLLISION = 2'd1,
    TX_ACK       = 2'd2,
    TX_MEASURE   = 2'd3
  } tx_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS    = 2'd0,
    CFG_LISTEN_WINDOW  = 2'd1,
    CFG_SEND_WINDOW    = 2'd2,
    CFG_MEASURE_WINDOW = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [MS_W-1:0] listen;
    logic [MS_W-1:0] send;
    logic [MS_W-1:0] measure;
  } win_cfg_t;

  typedef struct packed {
    proto_state_t      state;
    logic              entered;
    logic [MS_W-1:0]   elapsed;
    logic [ADDR_W-1:0] peer;
    logic [ADDR_W-1:0] neighbor;
    logic              is_master;
    logic              measure_line;
    logic              beacon_flag;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    state:        ST_RESET,
    entered:      1'b1,
    elapsed:      '0,
    peer:         '0,
    neighbor:     ADDR_ALL_ONES,
    is_master:    1'b0,
    measure_line: 1'b0,
    beacon_flag:  1'b0
  };

  typedef struct packed {
    logic              valid;
    tx_kind_t          kind;
    logic [ADDR_W-1:0] dest;
  } tx_t;

  localparam tx_t TX_NONE = '{valid: 1'b0, kind: TX_BEACON, dest: '0};

  typedef struct packed {
    ctx_t ctx;
    tx_t  tx;
    logic again;
  } eval_res_t;

  typedef struct packed {
    ctx_t ctx;
    tx_t  tx;
  } settle_res_t;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        kind;
    logic [ADDR_W-1:0] src;
  } item_t;

  typedef struct packed {
    tx_t          tx;
    logic         measuring;
    logic         beacon_line;
    proto_state_t state;
  } result_t;

  // One evaluation of the current state. The again flag asks for another
  // evaluation because something moved.
  function automatic eval_res_t eval_step(input ctx_t c, input logic has_msg,
                                          input logic [7:0] kind,
                                          input logic [ADDR_W-1:0] src,
                                          input win_cfg_t w);
    eval_res_t r;
    r.ctx   = c;
    r.tx    = TX_NONE;
    r.again = 1'b0;
    unique case (c.state)
      ST_RESET: begin
        r.ctx.beacon_flag = 1'b0;
        r.ctx.is_master   = 1'b0;
        r.ctx.state       = ST_SCAN;
        r.ctx.entered     = 1'b1;
        r.again           = 1'b1;
      end
      ST_SCAN: begin
        if (c.entered) begin
          r.ctx.elapsed = '0;
          r.ctx.entered = 1'b0;
          r.again       = 1'b1;
        end else if (c.elapsed <= w.listen) begin
          if (has_msg && kind == MSG_BEACON) begin
            r.ctx.peer    = src;
            r.ctx.state   = ST_DETECTED;
            r.ctx.entered = 1'b1;
            r.again       = 1'b1;
          end else if (has_msg && kind == MSG_COLLISION) begin
            r.ctx.peer     = src;
            r.ctx.neighbor = src;
            r.ctx.state    = ST_SENDACK;
            r.ctx.entered  = 1'b1;
            r.again        = 1'b1;
          end
        end else begin
          r.ctx.state   = ST_BEACON;
          r.ctx.entered = 1'b1;
          r.again       = 1'b1;
        end
      end
      ST_DETECTED, ST_SENDACK: begin
        if (c.entered) begin
          r.ctx.elapsed = '0;
          r.ctx.entered = 1'b0;
        end
        if (r.ctx.elapsed <= w.send) begin
          r.tx.valid = 1'b1;
          r.tx.kind  = (c.state == ST_DETECTED) ? TX_COLLISION : TX_ACK;
          r.tx.dest  = c.peer;
        end else begin
          r.ctx.state   = (c.state == ST_DETECTED) ? ST_WAITACK : ST_SYNCED;
          r.ctx.entered = 1'b1;
          r.again       = 1'b1;
        end
      end
      ST_WAITACK: begin
        r.ctx.entered = 1'b0;
        if (has_msg && kind == MSG_ACK && src == c.peer) begin
          r.ctx.neighbor  = c.peer;
          r.ctx.is_master = 1'b1;
          r.ctx.state     = ST_SYNCED;
          r.ctx.entered   = 1'b1;
          r.again         = 1'b1;
        end
      end
      ST_SYNCED: begin
        r.ctx.state   = c.is_master ? ST_TAKE : ST_CHECK;
        r.ctx.entered = 1'b1;
        r.again       = 1'b1;
      end
      ST_BEACON: begin
        if (c.entered) begin
          r.ctx.elapsed     = '0;
          r.ctx.beacon_flag = 1'b1;
          r.ctx.entered     = 1'b0;
        end
        if (r.ctx.elapsed <= w.send) begin
          r.tx.valid = 1'b1;
          r.tx.kind  = TX_BEACON;
          r.tx.dest  = '0;
        end else begin
          r.ctx.state   = ST_RESET;
          r.ctx.entered = 1'b1;
          r.again       = 1'b1;
        end
      end
      ST_CHECK: begin
        if (c.entered) begin
          r.ctx.elapsed      = '0;
          r.ctx.measure_line = 1'b0;
          r.ctx.entered      = 1'b0;
          r.again            = 1'b1;
        end else begin
          if (has_msg && kind == MSG_MEASURE && src == c.neighbor) begin
            r.ctx.state   = ST_WAITSLOT;
            r.ctx.entered = 1'b1;
            r.again       = 1'b1;
          end
          // A timeout in the same evaluation overrides an accepted slot.
          if (c.elapsed > w.listen) begin
            r.ctx.state   = ST_RESET;
            r.ctx.entered = 1'b1;
            r.again       = 1'b1;
          end
        end
      end
      ST_WAITSLOT: begin
        if (c.entered) begin
          r.ctx.elapsed = '0;
          r.ctx.entered = 1'b0;
        end
        if (r.ctx.elapsed >= w.measure) begin
          r.ctx.state   = ST_TAKE;
          r.ctx.entered = 1'b1;
          r.again       = 1'b1;
        end
      end
      ST_TAKE: begin
        if (c.entered) begin
          r.ctx.elapsed      = '0;
          r.ctx.measure_line = 1'b1;
          r.ctx.entered      = 1'b0;
        end
        if (r.ctx.elapsed <= w.send) begin
          r.tx.valid = 1'b1;
          r.tx.kind  = TX_MEASURE;
          r.tx.dest  = '0;
        end else if (r.ctx.elapsed >= w.measure) begin
          r.ctx.state   = ST_CHECK;
          r.ctx.entered = 1'b1;
          r.again       = 1'b1;
        end
      end
      default: begin
        r.ctx.state   = ST_RESET;
        r.ctx.entered = 1'b1;
        r.again       = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Runs evaluations until the state stops moving. A message is offered to
  // the first evaluation only.
  function automatic settle_res_t settle(input ctx_t c, input logic has_msg,
                                         input logic [7:0] kind,
                                         input logic [ADDR_W-1:0] src,
                                         input win_cfg_t w);
    settle_res_t s;
    eval_res_t   e;
    logic        done;
    s.ctx = c;
    s.tx  = TX_NONE;
    done  = 1'b0;
    for (int i = 0; i < EVAL_STEPS; i++) begin
      if (!done) begin
        e     = eval_step(s.ctx, has_msg && (i == 0), kind, src, w);
        s.ctx = e.ctx;
        if (e.tx.valid) begin
          s.tx = e.tx;
        end
        done = !e.again;
      end
    end
    return s;
  endfunction

endpackage

FILE: design/rtssc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Decodes writes on the configuration port and holds the timing windows.
// ----------------------------------------------------------------------------
module rtssc_cfg_regs
  import rtssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output win_cfg_t              win_o
);

  win_cfg_t win_r;
  win_cfg_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (we_i) begin
      unique case (cfg_index_t'(index_i))
        CFG_OWN_ADDRESS: begin
          // The own address only travels in transmitted frames; no result
          // field depends on it, so it is not stored here.
          win_nxt = win_r;
        end
        CFG_LISTEN_WINDOW:  win_nxt.listen  = wdata_i[MS_W-1:0];
        CFG_SEND_WINDOW:    win_nxt.send    = wdata_i[MS_W-1:0];
        CFG_MEASURE_WINDOW: win_nxt.measure = wdata_i[MS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.listen  <= LISTEN_RESET;
      win_r.send    <= SEND_RESET;
      win_r.measure <= MEASURE_RESET;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win_o = win_r;

endmodule

FILE: design/rtssc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Captures one input transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module rtssc_in_stage
  import rtssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  item_t s_item_i,
  input  logic  down_ready_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  advance;

  assign advance   = valid_r && down_ready_i;
  assign s_ready_o = !valid_r || down_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (s_valid_i && s_ready_o) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_i && s_ready_o) begin
      item_r <= s_item_i;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

FILE: design/rtssc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protocol core
// Holds the controller context and computes the result of one item.
// ----------------------------------------------------------------------------
module rtssc_core
  import rtssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire_i,
  input  item_t    item_i,
  input  win_cfg_t win_i,
  output result_t  result_o
);

  ctx_t        ctx_r;
  ctx_t        ctx_nxt;
  settle_res_t pre;
  settle_res_t post;
  ctx_t        applied;
  logic        is_msg;

  assign is_msg = (item_i.opcode == OP_MESSAGE);

  always_comb begin
    // Settle first with the current windows, which may have been rewritten
    // since the last item. Transmit requests from this pass are dropped.
    pre     = settle(ctx_r, 1'b0, item_i.kind, item_i.src, win_i);
    applied = pre.ctx;
    if (!is_msg && applied.elapsed != ELAPSED_MAX) begin
      applied.elapsed = applied.elapsed + 1'b1;
    end
    post    = settle(applied, is_msg, item_i.kind, item_i.src, win_i);
    ctx_nxt = fire_i ? post.ctx : ctx_r;

    result_o.tx          = post.tx;
    result_o.measuring   = post.ctx.measure_line;
    result_o.beacon_line = post.ctx.beacon_flag;
    result_o.state       = post.ctx.state;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= CTX_RESET;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

FILE: design/rtssc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module rtssc_out_stage
  import rtssc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    m_ready_i,
  output result_t result_o
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // A held result that is being taken this cycle frees the slot at once.
  assign ready_o = !valid_r || m_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (m_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule

FILE: design/radio_time_slot_sync_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio time slot sync controller
// Lets two sensors on one radio channel agree on alternating measurement
// slots and reports one transmit request and status word per event.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one event per transaction: a millisecond tick
//   (in_tuser low) or a received message (in_tuser high, id and source
//   address in in_tdata). Every event yields exactly one result transaction
//   with the transmit request, the measuring and beacon lines and the state.
//   An event is registered on entry, and the protocol step on the held event
//   is loaded into the result register, which drives out_tvalid. While the
//   receiver does not stall, one event is accepted every cycle; the rate is
//   set by the combinational protocol step between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register absorbs one more event before in_tready drops.
//   Reset clears both stages, loads the default timing windows and returns
//   the protocol to its reset state. Configuration writes take effect at the
//   next clock edge and are meant to be issued while no event is in flight.
// ----------------------------------------------------------------------------
module radio_time_slot_sync_controller
  import rtssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: message_kind[7:0], sender_address[31:8].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: opcode[0].
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: transmit_valid[0], transmit_kind[2:1],
  // transmit_destination[26:3], measuring[27], beacon_line[28],
  // protocol_state[32:29], zero fill[39:33].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  win_cfg_t win;
  item_t    in_item;
  item_t    held_item;
  logic     held_valid;
  logic     core_ready;
  logic     fire;
  result_t  core_result;
  result_t  out_result;

  assign in_item.opcode = in_tuser;
  assign in_item.kind   = in_tdata[7:0];
  assign in_item.src    = in_tdata[IN_TDATA_W-1:8];

  assign fire = held_valid && core_ready;

  rtssc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .we_i    (cfg_we),
    .index_i (cfg_index),
    .wdata_i (cfg_wdata),
    .win_o   (win)
  );

  rtssc_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_valid_i    (in_tvalid),
    .s_ready_o    (in_tready),
    .s_item_i     (in_item),
    .down_ready_i (core_ready),
    .valid_o      (held_valid),
    .item_o       (held_item)
  );

  rtssc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (fire),
    .item_i   (held_item),
    .win_i    (win),
    .result_o (core_result)
  );

  rtssc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (fire),
    .result_i  (core_result),
    .ready_o   (core_ready),
    .valid_o   (out_tvalid),
    .m_ready_i (out_tready),
    .result_o  (out_result)
  );

  assign out_tdata = {7'd0, out_result.state, out_result.beacon_line,
                      out_result.measuring, out_result.tx.dest,
                      out_result.tx.kind, out_result.tx.valid};

endmodule

FILE: design/rtssc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result stream checker
// Checks consistency of the result transactions seen on the output port.
// ----------------------------------------------------------------------------
module rtssc_checker
  import rtssc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic              tx_valid;
  logic [1:0]        tx_kind;
  logic [ADDR_W-1:0] tx_dest;
  logic              measuring;
  logic              beacon_line;
  logic [3:0]        state;
  logic              taken;

  assign tx_valid    = out_tdata[0];
  assign tx_kind     = out_tdata[2:1];
  assign tx_dest     = out_tdata[26:3];
  assign measuring   = out_tdata[27];
  assign beacon_line = out_tdata[28];
  assign state       = out_tdata[32:29];
  assign taken       = out_tvalid && out_tready;

  // Without a transmit request the kind and destination read as zero.
  a_idle_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && !tx_valid) |-> (tx_kind == TX_BEACON && tx_dest == '0))
    else $error("transmit fields not cleared without a request");

  // Beacon and measure frames are broadcast with a zero destination.
  a_broadcast_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && tx_valid && (tx_kind == TX_BEACON || tx_kind == TX_MEASURE))
    |-> (tx_dest == '0))
    else $error("broadcast frame carries a destination");

  // The measuring line is high exactly while the slot is held.
  a_measure_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    taken |-> (measuring == (state == ST_TAKE)))
    else $error("measuring line out of step with slot state");

  // Beaconing always shows the beacon line.
  a_beacon_line: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && state == ST_BEACON) |-> beacon_line)
    else $error("beacon state without beacon line");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind radio_time_slot_sync_controller rtssc_checker u_rtssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
